// ===== rtl/core/mrmct_pkg.sv =====
// Package for the masked register map change tracker.
// Holds map size, command codes, config register indexes and reset values.
// No dependencies.
`default_nettype none

package mrmct_pkg;

    localparam int MAP_BYTES = 16;
    localparam int MAP_AW    = 4;

    localparam logic [4:0] RUN_MAX = 5'd16;

    localparam logic [2:0] CMD_READ      = 3'd0;
    localparam logic [2:0] CMD_WR_CHECK  = 3'd1;
    localparam logic [2:0] CMD_WR_LOCAL  = 3'd2;
    localparam logic [2:0] CMD_TAKE      = 3'd3;
    localparam logic [2:0] CMD_CLEAR     = 3'd4;

    localparam logic [7:0] CFG_MASK_LOW  = 8'd0;
    localparam logic [7:0] CFG_MASK_HIGH = 8'd1;

    localparam logic [63:0] MASK_LOW_RST  = 64'h0;
    localparam logic [63:0] MASK_HIGH_RST = 64'h0000_0000_0001_0000;

    typedef logic [MAP_BYTES-1:0] t_flags;

endpackage

`default_nettype wire

// ===== rtl/core/mrmct_if.sv =====
// Channel interfaces of the masked register map change tracker:
// request, response and configuration write. No dependencies.
`default_nettype none

interface mrmct_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] addr;
    logic [7:0] wr_value;
    logic       last_byte;

    modport source (output valid, cmd, addr, wr_value, last_byte, input ready);
    modport sink   (input valid, cmd, addr, wr_value, last_byte, output ready);
endinterface

interface mrmct_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic       accepted;
    logic       change_found;
    logic [3:0] change_addr;
    logic [7:0] change_bits;
    logic [4:0] written_count;
    logic       any_change_seen;

    modport source (output valid, data_out, accepted, change_found, change_addr,
                    change_bits, written_count, any_change_seen, input ready);
    modport sink   (input valid, data_out, accepted, change_found, change_addr,
                    change_bits, written_count, any_change_seen, output ready);
endinterface

interface mrmct_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/masked_register_map_change_tracker.sv =====
// Masked byte register map with change tracking (top level).
// Uses mrmct_pkg and the channel interfaces in mrmct_if.sv.
//
//   channel  | port   | dir | payload
//   ---------+--------+-----+------------------------------------------------
//   request  | i_req  | in  | cmd, addr, wr_value, last_byte
//   response | o_rsp  | out | data_out, accepted, change_found, change_addr,
//            |        |     | change_bits, written_count, any_change_seen
//   config   | i_cfg  | in  | index, data (64-bit mask registers 0 and 1)
//
// Each request has an accept step and an execute step: the accept edge reads
// the value and change memories, the execute state modifies and writes back
// and loads the response register; no request is taken until it ends.
// A new request is taken while a response waits; the modify cycle holds
// only if the response register is still full. Reset (synchronous, active
// low) empties the map through per-entry valid and pending flags, no sweep.
`default_nettype none

module masked_register_map_change_tracker (
    input  wire              i_clk,
    input  wire              i_rst_n,
    mrmct_req_if.sink        i_req,
    mrmct_rsp_if.source      o_rsp,
    mrmct_cfg_if.sink        i_cfg
);
    import mrmct_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;

    logic [63:0] r_mask_lo, r_mask_hi;

    // Memories: value and change bytes
    logic [7:0] r_val_mem [MAP_BYTES];
    logic [7:0] r_chg_mem [MAP_BYTES];
    logic [7:0] r_rd_val, r_rd_chg;

    t_flags r_val_vld;
    t_flags r_pend;

    logic [4:0] r_run;
    logic       r_sticky;

    // Latched request
    logic [2:0]        r_cmd;
    logic [7:0]        r_addr;
    logic [7:0]        r_wr_value;
    logic              r_last;
    logic              r_found;
    logic [MAP_AW-1:0] r_idx;

    // Response register
    logic       r_out_valid;
    logic [7:0] r_data_out;
    logic       r_accepted;
    logic       r_change_found;
    logic [3:0] r_change_addr;
    logic [7:0] r_change_bits;
    logic [4:0] r_written_count;

    logic              req_fire;
    logic              exec_go;
    logic              enc_found;
    logic [MAP_AW-1:0] enc_idx;
    logic [MAP_AW-1:0] rd_k;
    logic [MAP_AW-1:0] k;
    logic              in_range;
    logic [7:0]        mask;
    logic [7:0]        old_v;
    logic [7:0]        new_v;
    logic [7:0]        diff;
    logic [4:0]        run_inc;

    logic              val_we;
    logic [7:0]        val_wd;
    logic              chg_we;
    logic [7:0]        chg_wd;

    logic [7:0]        n_data_out;
    logic              n_accepted;
    logic [4:0]        n_written_count;
    logic [4:0]        n_run;
    logic              n_sticky;
    t_flags            n_val_vld;
    t_flags            n_pend;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign exec_go     = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    // Lowest pending entry
    always_comb begin
        enc_found = 1'b0;
        enc_idx   = '0;
        for (int i = MAP_BYTES - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                enc_found = 1'b1;
                enc_idx   = MAP_AW'(i);
            end
        end
    end

    assign rd_k = (i_req.cmd == CMD_TAKE) ? enc_idx : i_req.addr[MAP_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_rd_val <= r_val_mem[rd_k];
            r_rd_chg <= r_chg_mem[rd_k];
        end
        if (val_we) begin
            r_val_mem[k] <= val_wd;
        end
        if (chg_we) begin
            r_chg_mem[k] <= chg_wd;
        end
    end

    assign k        = (r_cmd == CMD_TAKE) ? r_idx : r_addr[MAP_AW-1:0];
    assign in_range = (r_addr < 8'(MAP_BYTES));
    assign mask     = r_addr[3] ? r_mask_hi[{r_addr[2:0], 3'b000} +: 8]
                                : r_mask_lo[{r_addr[2:0], 3'b000} +: 8];
    assign old_v    = r_val_vld[k] ? r_rd_val : 8'h00;
    assign new_v    = r_wr_value & mask;
    assign diff     = old_v ^ new_v;
    assign run_inc  = (r_run < RUN_MAX) ? r_run + 5'd1 : r_run;

    always_comb begin
        val_we          = 1'b0;
        val_wd          = r_wr_value;
        chg_we          = 1'b0;
        chg_wd          = diff;
        n_data_out      = 8'h00;
        n_accepted      = 1'b0;
        n_written_count = 5'd0;
        n_run           = r_run;
        n_sticky        = r_sticky;
        n_val_vld       = r_val_vld;
        n_pend          = r_pend;
        unique case (r_cmd)
            CMD_READ: begin
                if (in_range) begin
                    n_data_out = old_v;
                    n_accepted = 1'b1;
                end
            end
            CMD_WR_CHECK, CMD_WR_LOCAL: begin
                if (in_range) begin
                    n_accepted = 1'b1;
                    n_run      = run_inc;
                    if (r_cmd == CMD_WR_LOCAL) begin
                        val_we       = 1'b1;
                        n_val_vld[k] = 1'b1;
                    end else if (mask != 8'h00) begin
                        val_we       = 1'b1;
                        val_wd       = new_v;
                        n_val_vld[k] = 1'b1;
                        if (diff != 8'h00) begin
                            chg_we    = 1'b1;
                            n_pend[k] = 1'b1;
                            n_sticky  = 1'b1;
                        end
                    end
                end
                n_written_count = n_run;
                if (r_last) begin
                    n_run = 5'd0;
                end
            end
            CMD_TAKE: begin
                if (r_found) begin
                    n_data_out = old_v;
                    n_pend[k]  = 1'b0;
                end
            end
            CMD_CLEAR: begin
                n_val_vld = '0;
                n_pend    = '0;
                n_run     = 5'd0;
            end
            default: begin
            end
        endcase
        if (!exec_go) begin
            val_we = 1'b0;
            chg_we = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (req_fire) n_state = S_EXEC;
            S_EXEC: if (exec_go)  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mask_lo   <= MASK_LOW_RST;
            r_mask_hi   <= MASK_HIGH_RST;
            r_val_vld   <= '0;
            r_pend      <= '0;
            r_run       <= 5'd0;
            r_sticky    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                if (i_cfg.index == CFG_MASK_LOW) begin
                    r_mask_lo <= i_cfg.data;
                end else if (i_cfg.index == CFG_MASK_HIGH) begin
                    r_mask_hi <= i_cfg.data;
                end
            end
            if (exec_go) begin
                r_val_vld   <= n_val_vld;
                r_pend      <= n_pend;
                r_run       <= n_run;
                r_sticky    <= n_sticky;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_cmd      <= i_req.cmd;
            r_addr     <= i_req.addr;
            r_wr_value <= i_req.wr_value;
            r_last     <= i_req.last_byte;
            r_found    <= enc_found;
            r_idx      <= enc_idx;
        end
        if (exec_go) begin
            r_data_out      <= n_data_out;
            r_accepted      <= n_accepted;
            r_change_found  <= (r_cmd == CMD_TAKE) && r_found;
            r_change_addr   <= ((r_cmd == CMD_TAKE) && r_found) ? 4'(r_idx) : 4'd0;
            r_change_bits   <= ((r_cmd == CMD_TAKE) && r_found) ? r_rd_chg : 8'h00;
            r_written_count <= n_written_count;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.data_out        = r_data_out;
    assign o_rsp.accepted        = r_accepted;
    assign o_rsp.change_found    = r_change_found;
    assign o_rsp.change_addr     = r_change_addr;
    assign o_rsp.change_bits     = r_change_bits;
    assign o_rsp.written_count   = r_written_count;
    assign o_rsp.any_change_seen = r_sticky;

endmodule

`default_nettype wire
